FILE: sv/tbhr_pkg.sv
package tbhr_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_READ     = 2'd1,
    ACT_TRUNCATE = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] length;
    logic [14:0] weight;
    logic [7:0]  role;
    logic [31:0] seq;
  } rec_t;

  localparam int unsigned BUDGET_W      = 20;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 20'd4096;
  localparam int unsigned IN_DATA_W     = 72;
  localparam int unsigned OUT_DATA_W    = 144;
  localparam int unsigned OUT_PAD_W     = 6;

endpackage

FILE: sv/tbhr_ring_mem.sv
module tbhr_ring_mem
  import tbhr_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rec_t          wr_rec,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rec_t          rd_rec
);

  rec_t mem [DEPTH];
  rec_t rd_rec_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_rec_r <= mem[rd_addr];
    end
  end

  assign rd_rec = rd_rec_r;

endmodule

FILE: sv/token_budget_history_ring_core.sv
// Flow: a push with no eviction or a clear goes idle, eval, done; a read adds a read
// state before done. Each evicted or truncated entry adds a drop or trunc state and
// a return to eval, as the entry store has a single registered read port.
// Throughput: one operation at a time; in_tready is high only while idle.
// Reset (rst_n low, synchronous) empties the ring, zeroes the sequence counter and
// sets token_budget to 4096; the entry store itself is not cleared.
module token_budget_history_ring_core
  import tbhr_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [BUDGET_W-1:0]   cfg_wr_data,   // token_budget
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // role[7:0], text_length[23:8], timestamp[55:24], position[71:56]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[0], entry_count[7:1], window_weight[27:8], dropped_count[34:28],
  // entry_sequence[66:35], entry_role[74:67], entry_weight[89:75],
  // entry_length[105:90], entry_time[137:106], zero pad[143:138]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned SPAN = 2 * RING_DEPTH;
  localparam int unsigned PW   = $clog2(SPAN);
  localparam int unsigned AW   = $clog2(RING_DEPTH);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EVAL  = 6'b000010,
    ST_DROP  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_TRUNC = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(SPAN - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(SPAN - 1) : p - PW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
    return (p >= PW'(RING_DEPTH)) ? AW'(p - PW'(RING_DEPTH)) : AW'(p);
  endfunction

  state_t              state_r, state_nxt;
  logic [PW-1:0]       oldest_r, oldest_nxt;
  logic [PW-1:0]       newest_r, newest_nxt;
  logic [BUDGET_W-1:0] held_r, held_nxt;
  logic [31:0]         seq_r, seq_nxt;
  logic [BUDGET_W-1:0] budget_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  action_t             act_r, act_nxt;
  logic [7:0]          role_r, role_nxt;
  logic [15:0]         len_r, len_nxt;
  logic [31:0]         stamp_r, stamp_nxt;
  logic [15:0]         pos_r, pos_nxt;
  logic [14:0]         wt_r, wt_nxt;
  logic [PW-1:0]       dropped_r, dropped_nxt;
  logic                status_r, status_nxt;
  rec_t                rec_r, rec_nxt;

  logic                mem_wr_en, mem_rd_en;
  logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
  rec_t                mem_wr_rec, mem_rd_rec;

  logic [PW:0]         diff;
  logic [PW-1:0]       count;
  logic [PW:0]         idx_sum;
  logic [PW-1:0]       idx_ptr;
  logic [BUDGET_W:0]   sum_w;
  logic                in_xfer;

  tbhr_ring_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_rec  (mem_wr_rec),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_rec  (mem_rd_rec)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    diff    = {1'b0, newest_r} - {1'b0, oldest_r};
    count   = diff[PW] ? PW'(diff + (PW + 1)'(SPAN)) : diff[PW-1:0];
    idx_sum = {1'b0, oldest_r} + {1'b0, PW'(pos_r)};
    idx_ptr = (idx_sum >= (PW + 1)'(SPAN)) ? PW'(idx_sum - (PW + 1)'(SPAN))
                                            : idx_sum[PW-1:0];
    sum_w   = {1'b0, held_r} + (BUDGET_W + 1)'(wt_r);
  end

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    newest_nxt    = newest_r;
    held_nxt      = held_r;
    seq_nxt       = seq_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    act_nxt       = act_r;
    role_nxt      = role_r;
    len_nxt       = len_r;
    stamp_nxt     = stamp_r;
    pos_nxt       = pos_r;
    wt_nxt        = wt_r;
    dropped_nxt   = dropped_r;
    status_nxt    = status_r;
    rec_nxt       = rec_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = slot_of(newest_r);
    mem_wr_rec    = '{stamp: stamp_r, length: len_r, weight: wt_r, role: role_r,
                      seq: seq_r};
    mem_rd_en     = 1'b0;
    mem_rd_addr   = slot_of(oldest_r);

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          act_nxt     = action_t'(in_tuser);
          role_nxt    = in_tdata[7:0];
          len_nxt     = in_tdata[23:8];
          stamp_nxt   = in_tdata[55:24];
          pos_nxt     = in_tdata[71:56];
          wt_nxt      = 15'((17'(in_tdata[23:8]) + 17'd3) >> 2);
          dropped_nxt = '0;
          status_nxt  = 1'b0;
          rec_nxt     = '0;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        case (act_r)
          ACT_PUSH: begin
            if ((count >= PW'(RING_DEPTH)) ||
                ((count != '0) && (sum_w > {1'b0, budget_r}))) begin
              mem_rd_en = 1'b1;
              state_nxt = ST_DROP;
            end else begin
              mem_wr_en  = 1'b1;
              rec_nxt    = mem_wr_rec;
              seq_nxt    = seq_r + 32'd1;
              newest_nxt = ptr_inc(newest_r);
              held_nxt   = sum_w[BUDGET_W-1:0];
              state_nxt  = ST_DONE;
            end
          end
          ACT_READ: begin
            if (17'(pos_r) >= 17'(count)) begin
              status_nxt = 1'b1;
              state_nxt  = ST_DONE;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = slot_of(idx_ptr);
              state_nxt   = ST_READ;
            end
          end
          ACT_TRUNCATE: begin
            if (17'(count) > 17'(pos_r)) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = slot_of(ptr_dec(newest_r));
              state_nxt   = ST_TRUNC;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          ACT_CLEAR: begin
            dropped_nxt = count;
            oldest_nxt  = '0;
            newest_nxt  = '0;
            held_nxt    = '0;
            seq_nxt     = '0;
            state_nxt   = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DROP: begin
        held_nxt    = held_r - BUDGET_W'(mem_rd_rec.weight);
        oldest_nxt  = ptr_inc(oldest_r);
        dropped_nxt = dropped_r + PW'(1);
        state_nxt   = ST_EVAL;
      end
      ST_TRUNC: begin
        held_nxt    = held_r - BUDGET_W'(mem_rd_rec.weight);
        newest_nxt  = ptr_dec(newest_r);
        dropped_nxt = dropped_r + PW'(1);
        state_nxt   = ST_EVAL;
      end
      ST_READ: begin
        rec_nxt   = mem_rd_rec;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {OUT_PAD_W'(0), rec_r.stamp, rec_r.length, rec_r.weight,
                           rec_r.role, rec_r.seq, 7'(dropped_r), held_r, 7'(count),
                           status_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      newest_r    <= '0;
      held_r      <= '0;
      seq_r       <= '0;
      budget_r    <= BUDGET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      newest_r    <= newest_nxt;
      held_r      <= held_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    act_r      <= act_nxt;
    role_r     <= role_nxt;
    len_r      <= len_nxt;
    stamp_r    <= stamp_nxt;
    pos_r      <= pos_nxt;
    wt_r       <= wt_nxt;
    dropped_r  <= dropped_nxt;
    status_r   <= status_nxt;
    rec_r      <= rec_nxt;
  end

endmodule

FILE: tb/token_budget_history_ring_core_test.sv
`timescale 1ns / 1ps

module token_budget_history_ring_core_test;
  import tbhr_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned PTR_SPAN    = 2 * DEPTH;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned SHOW_LIMIT  = 10;

  typedef struct {
    logic        status;
    logic [6:0]  count;
    logic [19:0] weight;
    logic [6:0]  dropped;
    rec_t        rec;
  } ring_reply_t;

  class ring_tracker;
    rec_t        slots[DEPTH];
    int unsigned oldest_ptr = 0;
    int unsigned newest_ptr = 0;
    int unsigned held_weight = 0;
    logic [31:0] seq_counter = '0;
    int unsigned budget = BUDGET_RESET;
    ring_reply_t pending_replies[$];
    int unsigned fail_count = 0;
    int unsigned reply_index = 0;

    function int unsigned held_count();
      return (newest_ptr + PTR_SPAN - oldest_ptr) % PTR_SPAN;
    endfunction

    function void drop_oldest();
      held_weight -= slots[oldest_ptr % DEPTH].weight;
      oldest_ptr = (oldest_ptr + 1) % PTR_SPAN;
    endfunction

    function void note_op(action_t act, logic [7:0] role, logic [15:0] len,
                          logic [31:0] stamp, logic [15:0] pos);
      ring_reply_t r;
      int unsigned w;
      int unsigned dropped;
      int unsigned n;
      r.status = 1'b0;
      r.rec = '0;
      dropped = 0;
      case (act)
        ACT_PUSH: begin
          w = (32'(len) + 3) / 4;
          while (held_count() >= DEPTH) begin
            drop_oldest();
            dropped++;
          end
          while (held_count() > 0 && held_weight + w > budget) begin
            drop_oldest();
            dropped++;
          end
          slots[newest_ptr % DEPTH] = '{stamp: stamp, length: len, weight: 15'(w),
                                        role: role, seq: seq_counter};
          r.rec = slots[newest_ptr % DEPTH];
          seq_counter = seq_counter + 32'd1;
          newest_ptr = (newest_ptr + 1) % PTR_SPAN;
          held_weight += w;
        end
        ACT_READ: begin
          if (32'(pos) >= held_count()) begin
            r.status = 1'b1;
          end else begin
            r.rec = slots[(oldest_ptr + 32'(pos)) % DEPTH];
          end
        end
        ACT_TRUNCATE: begin
          n = held_count();
          if (32'(pos) < n) begin
            dropped = n - 32'(pos);
            while (held_count() > 32'(pos)) begin
              newest_ptr = (newest_ptr + PTR_SPAN - 1) % PTR_SPAN;
              held_weight -= slots[newest_ptr % DEPTH].weight;
            end
          end
        end
        default: begin
          dropped = held_count();
          oldest_ptr = 0;
          newest_ptr = 0;
          held_weight = 0;
          seq_counter = '0;
        end
      endcase
      r.count = 7'(held_count());
      r.weight = 20'(held_weight);
      r.dropped = 7'(dropped);
      pending_replies.push_back(r);
    endfunction

    function void check_field(string field, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        if (fail_count < SHOW_LIMIT)
          $display("result %0d %s: expected 0x%0h, got 0x%0h", reply_index, field, want, seen);
        fail_count++;
      end
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] d);
      ring_reply_t e;
      rec_t got;
      if (pending_replies.size() == 0) begin
        if (fail_count < SHOW_LIMIT)
          $display("result %0d not expected: 0x%0h", reply_index, d);
        fail_count++;
      end else begin
        e = pending_replies.pop_front();
        got = d[137:35];
        check_field("status", e.status, d[0]);
        check_field("entry_count", e.count, d[7:1]);
        check_field("window_weight", e.weight, d[27:8]);
        check_field("dropped_count", e.dropped, d[34:28]);
        check_field("entry_sequence", e.rec.seq, got.seq);
        check_field("entry_role", e.rec.role, got.role);
        check_field("entry_weight", e.rec.weight, got.weight);
        check_field("entry_length", e.rec.length, got.length);
        check_field("entry_time", e.rec.stamp, got.stamp);
      end
      reply_index++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [BUDGET_W-1:0]   cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = ACT_PUSH;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  bit                    steady = 1'b0;
  int unsigned           quiet_cycles = 0;
  ring_tracker           tracker = new();

  token_budget_history_ring_core #(
    .RING_DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_op(action_t act, logic [7:0] role, logic [15:0] len,
                         logic [31:0] stamp, logic [15:0] pos, bit drain = 1'b0);
    int unsigned gap;
    gap = pick_gap();
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && tracker.pending_replies.size() != 0) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {pos, stamp, len, role};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_op(act, role, len, stamp, pos);
  endtask

  task automatic set_budget(logic [BUDGET_W-1:0] value);
    in_tvalid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.budget = value;
  endtask

  task automatic random_ops(int unsigned items, int unsigned len_cap, int unsigned clear_pct);
    int unsigned r;
    int unsigned n;
    action_t act;
    logic [15:0] len;
    logic [15:0] pos;
    repeat (items) begin
      n = tracker.held_count();
      r = $urandom_range(0, 99);
      if (r < 65) act = ACT_PUSH;
      else if (r < 90) act = ACT_READ;
      else if (r < 100 - clear_pct) act = ACT_TRUNCATE;
      else act = ACT_CLEAR;
      r = $urandom_range(0, 99);
      if (r < 75) len = 16'($urandom_range(0, len_cap));
      else if (r < 90) len = 16'($urandom);
      else if (r < 95) len = 16'hffff;
      else len = 16'($urandom_range(0, 4));
      r = $urandom_range(0, 99);
      if (act == ACT_TRUNCATE && r < 70) pos = 16'(n - $urandom_range(0, (n < 3) ? n : 3));
      else if (r < 80) pos = 16'($urandom_range(0, n));
      else if (r < 95) pos = 16'($urandom);
      else pos = 16'hffff;
      send_op(act, 8'($urandom), len, $urandom, pos, $urandom_range(0, 99) == 0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_reply(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring
    send_op(ACT_READ, 8'h00, 16'd0, 32'h0, 16'd0);
    send_op(ACT_TRUNCATE, 8'h00, 16'd0, 32'h0, 16'd0);
    send_op(ACT_CLEAR, 8'h00, 16'd0, 32'h0, 16'd0);
    // weight rounding and field extremes
    send_op(ACT_PUSH, 8'h00, 16'd0, 32'h0000_0000, 16'd0);
    send_op(ACT_PUSH, 8'hff, 16'd1, 32'hffff_ffff, 16'hffff);
    send_op(ACT_PUSH, 8'h12, 16'd2, $urandom, 16'd0);
    send_op(ACT_PUSH, 8'h34, 16'd3, $urandom, 16'd0);
    send_op(ACT_PUSH, 8'h56, 16'd4, $urandom, 16'd0);
    send_op(ACT_PUSH, 8'h78, 16'd5, $urandom, 16'd0);
    send_op(ACT_READ, 8'h00, 16'd0, 32'h0, 16'd0);
    send_op(ACT_READ, 8'h00, 16'd0, 32'h0, 16'd5);
    send_op(ACT_READ, 8'h00, 16'd0, 32'h0, 16'd6);
    send_op(ACT_READ, 8'h00, 16'd0, 32'h0, 16'hffff);
    // truncate at, above and below the count
    send_op(ACT_TRUNCATE, 8'h00, 16'd0, 32'h0, 16'hffff);
    send_op(ACT_TRUNCATE, 8'h00, 16'd0, 32'h0, 16'd6);
    send_op(ACT_TRUNCATE, 8'h00, 16'd0, 32'h0, 16'd4);
    // budget eviction, then an oversize entry stored alone
    send_op(ACT_PUSH, 8'h9a, 16'd16380, $urandom, 16'd0);
    send_op(ACT_PUSH, 8'ha5, 16'hffff, $urandom, 16'd0);
    send_op(ACT_READ, 8'h00, 16'd0, 32'h0, 16'd0);
    send_op(ACT_PUSH, 8'h5a, 16'd4, $urandom, 16'd0);
    send_op(ACT_TRUNCATE, 8'h00, 16'd0, 32'h0, 16'd0);
    // clear restarts the sequence count
    send_op(ACT_PUSH, 8'h01, 16'd8, $urandom, 16'd0);
    send_op(ACT_PUSH, 8'h02, 16'd12, $urandom, 16'd0);
    send_op(ACT_CLEAR, 8'h00, 16'd0, 32'h0, 16'd0);
    send_op(ACT_PUSH, 8'h03, 16'd7, $urandom, 16'd0);
    send_op(ACT_READ, 8'h00, 16'd0, 32'h0, 16'd0);

    set_budget(20'hfffff);
    random_ops(250, 400, 0);
    set_budget(20'd0);
    steady = 1'b1;
    random_ops(100, 40, 2);
    steady = 1'b0;
    set_budget(20'd100);
    random_ops(150, 400, 3);
    set_budget(20'($urandom_range(1, 20'hffffe)));
    random_ops(150, 8000, 2);
    set_budget(BUDGET_RESET);
    random_ops(150, 1000, 2);

    in_tvalid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tbhr_pkg.sv
sv/tbhr_ring_mem.sv
sv/token_budget_history_ring_core.sv
tb/token_budget_history_ring_core_test.sv
